// File: rtl/rau_pkg.sv
// package of shared types and constants for the rational arithmetic unit
`default_nettype none
package rau_pkg;
  localparam int unsigned ModeWidth = 3;
  localparam int unsigned NumWidth  = 32;
  localparam int unsigned DenWidth  = 31;
  localparam int unsigned WideWidth = 64;

  localparam logic [ModeWidth-1:0] ModeAdd = 3'd0;
  localparam logic [ModeWidth-1:0] ModeSub = 3'd1;
  localparam logic [ModeWidth-1:0] ModeMul = 3'd2;
  localparam logic [ModeWidth-1:0] ModeDiv = 3'd3;
  localparam logic [ModeWidth-1:0] ModeGt  = 3'd4;
  localparam logic [ModeWidth-1:0] ModeGe  = 3'd5;
  localparam logic [ModeWidth-1:0] ModeLt  = 3'd6;
  localparam logic [ModeWidth-1:0] ModeLe  = 3'd7;

  typedef struct packed {
    logic [ModeWidth-1:0] mode;
    logic signed [NumWidth-1:0] a_numerator;
    logic [DenWidth-1:0] a_denominator;
    logic signed [NumWidth-1:0] b_numerator;
    logic [DenWidth-1:0] b_denominator;
  } req_t;

  typedef struct packed {
    logic signed [NumWidth-1:0] res_numerator;
    logic [DenWidth-1:0] res_denominator;
    logic compare_true;
    logic divide_by_zero;
    logic overflow;
  } res_t;

  // controller to datapath
  typedef struct packed {
    logic load;      // capture operands
    logic mul_a;     // first product pair
    logic mul_b;     // second product pair
    logic combine;   // form num/den
    logic gcd_init;  // magnitudes, start euclid
    logic div_start; // load divider operands
    logic div_step;  // one restoring divide bit
    logic gcd_next;  // x<=y, y<=r
    logic quo_num;   // store quotient as numerator
    logic quo_den;   // store quotient as denominator
    logic finish;    // form result
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic is_cmp;
    logic is_dz;
    logic den_zero;
    logic y_zero;
  } sts_t;
endpackage
`default_nettype wire

// File: rtl/rau_if.sv
// valid/ready channel interface
`default_nettype none
interface rau_if #(parameter type payload_t = logic);
  logic valid;
  logic ready;
  payload_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// File: rtl/rational_arithmetic_unit.sv
// top level of the rational arithmetic unit
// usage:
//   req channel takes mode and two fractions a and b (denominators positive)
//   res channel returns one result per request: reduced fraction and flags
//   modes 0..3 add, sub, mul, div; modes 4..7 compare a>b, a>=b, a<b, a<=b
//   comparisons give 0/1 with compare_true; division by a zero numerator
//   gives 0/1 with divide_by_zero; a reduced result wider than
//   OPERAND_WIDTH gives 0/1 with overflow
// sequence:
//   compare, divide by zero, zero denominator: products, combine, init, then finish
//   arithmetic: one divide per euclid step, then two divides for the quotients;
//   each remainder and quotient comes from one 64-bit restoring divider
//   that retires one bit per cycle, so the euclid step count sets the rate
// throughput: one request in flight; req ready only while idle
// reset: asynchronous active low, returns to idle with no result pending
// stall: a result holds on res while ready is low; no new request is taken
`default_nettype none
module rational_arithmetic_unit #(
  parameter int unsigned OPERAND_WIDTH = 32
) (
  input wire logic clk_i,
  input wire logic rst_ni,
  rau_if.sink      req,
  rau_if.source    res
);
  import rau_pkg::*;

  cmd_t cmd;
  sts_t sts;
  res_t res_data;

  // sequencing of the product, gcd and quotient phases
  rau_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (req.valid),
    .in_ready_o  (req.ready),
    .out_valid_o (res.valid),
    .out_ready_i (res.ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  // arithmetic and result registers
  rau_datapath #(.OPERAND_WIDTH(OPERAND_WIDTH)) u_datapath (
    .clk_i (clk_i),
    .req_i (req.data),
    .cmd_i (cmd),
    .sts_o (sts),
    .res_o (res_data)
  );

  assign res.data = res_data;
endmodule
`default_nettype wire

// File: rtl/rau_datapath.sv
// datapath: cross products, euclid remainder unit, quotient division, result format
`default_nettype none
module rau_datapath #(
  parameter int unsigned OPERAND_WIDTH = 32
) (
  input  wire logic         clk_i,
  input  wire rau_pkg::req_t req_i,
  input  wire rau_pkg::cmd_t cmd_i,
  output rau_pkg::sts_t     sts_o,
  output rau_pkg::res_t     res_o
);
  import rau_pkg::*;

  localparam logic [WideWidth-1:0] Lim = {{(WideWidth-1){1'b0}}, 1'b1} << (OPERAND_WIDTH - 1);

  req_t req_q;
  logic signed [WideWidth-1:0] p0_q, p1_q, p2_q, p3_q;
  logic signed [WideWidth-1:0] num_q, den_q;
  logic [WideWidth-1:0] nm_q, dm_q, x_q, y_q, g_q;
  logic neg_q, cmp_q;
  // restoring divider: dividend shift reg, remainder, divisor
  logic [WideWidth-1:0] dq_q, rem_q, dvs_q;
  logic [WideWidth:0] trial;
  res_t res_q, res_d;
  logic is_cmp, is_dz, cmp_c;

  assign is_cmp = req_q.mode[2];
  assign is_dz  = (req_q.mode == ModeDiv) && (req_q.b_numerator == '0);
  assign trial  = {rem_q, dq_q[WideWidth-1]} - {1'b0, dvs_q};

  always_comb begin
    case (req_q.mode)
      ModeGt:  cmp_c = p0_q > p1_q;
      ModeGe:  cmp_c = p0_q >= p1_q;
      ModeLt:  cmp_c = p0_q < p1_q;
      ModeLe:  cmp_c = p0_q <= p1_q;
      default: cmp_c = 1'b0;
    endcase
  end

  // result format, captured on finish
  always_comb begin
    res_d = '0;
    res_d.res_denominator = DenWidth'(1);
    if (is_cmp) res_d.compare_true = cmp_q;
    else if (is_dz) res_d.divide_by_zero = 1'b1;
    else if (den_q == '0) res_d.overflow = 1'b1;
    else if (nm_q == '0) begin
      // zero result reduces to 0/1
    end else if ((neg_q ? nm_q > Lim : nm_q > Lim - 1'b1) || dq_q > Lim - 1'b1) begin
      res_d.overflow = 1'b1;
    end else begin
      res_d.res_numerator = neg_q ? -nm_q[NumWidth-1:0] : nm_q[NumWidth-1:0];
      res_d.res_denominator = dq_q[DenWidth-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) req_q <= req_i;
    if (cmd_i.mul_a) begin
      p0_q <= WideWidth'(req_q.a_numerator) * $signed({1'b0, req_q.b_denominator});
      p1_q <= WideWidth'(req_q.b_numerator) * $signed({1'b0, req_q.a_denominator});
    end
    if (cmd_i.mul_b) begin
      cmp_q <= cmp_c;
      p2_q <= req_q.a_numerator * req_q.b_numerator;
      p3_q <= $signed({1'b0, req_q.a_denominator}) * $signed({1'b0, req_q.b_denominator});
    end
    if (cmd_i.combine) begin
      case (req_q.mode)
        ModeAdd: begin num_q <= p0_q + p1_q; den_q <= p3_q; end
        ModeSub: begin num_q <= p0_q - p1_q; den_q <= p3_q; end
        ModeMul: begin num_q <= p2_q; den_q <= p3_q; end
        default: begin num_q <= p0_q; den_q <= p1_q; end
      endcase
    end
    if (cmd_i.gcd_init) begin
      nm_q  <= num_q[WideWidth-1] ? -num_q : num_q;
      dm_q  <= den_q[WideWidth-1] ? -den_q : den_q;
      neg_q <= (num_q[WideWidth-1] != den_q[WideWidth-1]) && (num_q != '0);
      x_q   <= num_q[WideWidth-1] ? -num_q : num_q;
      y_q   <= den_q[WideWidth-1] ? -den_q : den_q;
    end
    if (cmd_i.div_start) begin
      // euclid divide of x by y; the quotient passes later take g from the final x
      if (!cmd_i.quo_num && !cmd_i.quo_den) begin
        dq_q  <= x_q;
        dvs_q <= y_q;
      end
      rem_q <= '0;
    end
    if (cmd_i.div_step) begin
      dq_q <= {dq_q[WideWidth-2:0], !trial[WideWidth]};
      rem_q <= trial[WideWidth] ? {rem_q[WideWidth-2:0], dq_q[WideWidth-1]}
                                : trial[WideWidth-1:0];
    end
    if (cmd_i.gcd_next) begin
      x_q <= y_q;
      y_q <= rem_q;
    end
    if (cmd_i.quo_num && cmd_i.div_start) begin
      g_q <= x_q; dq_q <= nm_q; dvs_q <= x_q;
    end
    if (cmd_i.quo_den && cmd_i.div_start) begin
      nm_q <= dq_q; dq_q <= dm_q; dvs_q <= g_q;
    end
    if (cmd_i.finish) res_q <= res_d;
  end

  assign sts_o = '{is_cmp: is_cmp, is_dz: is_dz, den_zero: den_q == '0, y_zero: y_q == '0};
  assign res_o = res_q;
endmodule
`default_nettype wire

// File: rtl/rau_ctrl.sv
// controller: sequences products, euclid loop and quotient divisions
`default_nettype none
module rau_ctrl (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_ready_o,
  output logic               out_valid_o,
  input  wire logic          out_ready_i,
  input  wire rau_pkg::sts_t sts_i,
  output rau_pkg::cmd_t      cmd_o
);
  import rau_pkg::*;

  typedef enum logic [3:0] {
    StIdle, StMulA, StMulB, StComb, StInit, StTest, StDiv, StNext,
    StQNum, StQDen, StDivQ, StFin, StOut
  } state_e;

  // which division the shared divider is running
  typedef enum logic [1:0] {
    PhGcd, PhNum, PhDen
  } phase_e;

  state_e state_q, state_d;
  logic [5:0] cnt_q, cnt_d;
  phase_e phase_q, phase_d;

  always_comb begin
    cmd_o = '0;
    state_d = state_q;
    cnt_d = cnt_q;
    phase_d = phase_q;
    in_ready_o = (state_q == StIdle);
    out_valid_o = (state_q == StOut);
    case (state_q)
      StIdle: if (in_valid_i) begin cmd_o.load = 1'b1; state_d = StMulA; end
      StMulA: begin cmd_o.mul_a = 1'b1; state_d = StMulB; end
      StMulB: begin cmd_o.mul_b = 1'b1; state_d = StComb; end
      StComb: begin
        cmd_o.combine = 1'b1;
        state_d = StInit;
      end
      StInit: begin
        cmd_o.gcd_init = 1'b1;
        if (sts_i.is_cmp || sts_i.is_dz || sts_i.den_zero) state_d = StFin;
        else state_d = StTest;
      end
      StTest: begin
        if (sts_i.y_zero) state_d = StQNum;
        else begin
          cmd_o.div_start = 1'b1; cnt_d = '0; phase_d = PhGcd; state_d = StDiv;
        end
      end
      StDiv: begin
        cmd_o.div_step = 1'b1;
        cnt_d = cnt_q + 6'd1;
        if (cnt_q == 6'd63) state_d = (phase_q == PhGcd) ? StNext
                                      : (phase_q == PhNum) ? StQDen : StFin;
      end
      StNext: begin cmd_o.gcd_next = 1'b1; state_d = StTest; end
      StQNum: begin
        cmd_o.div_start = 1'b1; cmd_o.quo_num = 1'b1;
        cnt_d = '0; phase_d = PhNum; state_d = StDiv;
      end
      StQDen: begin
        cmd_o.div_start = 1'b1; cmd_o.quo_den = 1'b1;
        cnt_d = '0; phase_d = PhDen; state_d = StDiv;
      end
      StFin: begin cmd_o.finish = 1'b1; state_d = StOut; end
      StOut: if (out_ready_i) state_d = StIdle;
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      cnt_q <= '0;
      phase_q <= PhGcd;
    end else begin
      state_q <= state_d;
      cnt_q <= cnt_d;
      phase_q <= phase_d;
    end
  end
endmodule
`default_nettype wire

// File: tb/rational_arithmetic_unit_test.sv
// self-checking testbench for the rational arithmetic unit
`timescale 1ns / 100ps
`default_nettype none
module rational_arithmetic_unit_test;
  import rau_pkg::*;

  localparam int unsigned OperandWidth = 32;
  localparam longint CycleLimit = 40_000_000;
  localparam int unsigned RandomRequests = 930;
  localparam int unsigned DrainCycles = 50;
  localparam int unsigned LongHold = 600;

  // golden fraction model plus the queue of results still owed by the block
  class fraction_scoreboard;
    res_t owed_q[$];
    int unsigned mismatches;

    function new();
      mismatches = 0;
    endfunction

    function res_t reduce_fraction(req_t r);
      longint an, ad, bn, bd, num, den, left, right;
      longint unsigned nm, dm, x, y, t, lim;
      bit neg;
      res_t o;
      an = {{32{r.a_numerator[31]}}, r.a_numerator};
      bn = {{32{r.b_numerator[31]}}, r.b_numerator};
      ad = {33'd0, r.a_denominator};
      bd = {33'd0, r.b_denominator};
      lim = 64'd1 << (OperandWidth - 1);
      o = '0;
      o.res_denominator = 31'd1;
      if (r.mode >= ModeGt) begin
        left = an * bd;
        right = bn * ad;
        case (r.mode)
          ModeGt: o.compare_true = left > right;
          ModeGe: o.compare_true = left >= right;
          ModeLt: o.compare_true = left < right;
          default: o.compare_true = left <= right;
        endcase
      end else if (r.mode == ModeDiv && bn == 0) begin
        o.divide_by_zero = 1'b1;
      end else begin
        case (r.mode)
          ModeAdd: begin num = an * bd + bn * ad; den = ad * bd; end
          ModeSub: begin num = an * bd - bn * ad; den = ad * bd; end
          ModeMul: begin num = an * bn; den = ad * bd; end
          default: begin num = an * bd; den = ad * bn; end
        endcase
        if (den == 0) begin
          o.overflow = 1'b1;
        end else begin
          nm = (num < 0) ? -num : num;
          dm = (den < 0) ? -den : den;
          neg = ((num < 0) != (den < 0)) && nm != 0;
          // euclid on magnitudes
          x = nm;
          y = dm;
          while (y != 0) begin
            t = x % y;
            x = y;
            y = t;
          end
          nm = nm / x;
          dm = dm / x;
          if (nm == 0) dm = 1;
          if ((neg ? nm > lim : nm > lim - 1) || dm > lim - 1) begin
            o.overflow = 1'b1;
          end else begin
            o.res_numerator = neg ? -nm[31:0] : nm[31:0];
            o.res_denominator = dm[30:0];
          end
        end
      end
      return o;
    endfunction

    function void note_request(req_t r);
      owed_q.push_back(reduce_fraction(r));
    endfunction

    function void check_result(res_t got);
      res_t want;
      if (owed_q.size() == 0) begin
        $error("result with nothing outstanding: %0d/%0d", got.res_numerator,
               got.res_denominator);
        mismatches++;
        return;
      end
      want = owed_q.pop_front();
      if (got.res_numerator !== want.res_numerator) begin
        $error("res_numerator expected %0d actual %0d", want.res_numerator,
               got.res_numerator);
        mismatches++;
      end
      if (got.res_denominator !== want.res_denominator) begin
        $error("res_denominator expected %0d actual %0d", want.res_denominator,
               got.res_denominator);
        mismatches++;
      end
      if (got.compare_true !== want.compare_true) begin
        $error("compare_true expected %0b actual %0b", want.compare_true,
               got.compare_true);
        mismatches++;
      end
      if (got.divide_by_zero !== want.divide_by_zero) begin
        $error("divide_by_zero expected %0b actual %0b", want.divide_by_zero,
               got.divide_by_zero);
        mismatches++;
      end
      if (got.overflow !== want.overflow) begin
        $error("overflow expected %0b actual %0b", want.overflow, got.overflow);
        mismatches++;
      end
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;
  longint cycles;

  rau_if #(.payload_t(req_t)) req_ch ();
  rau_if #(.payload_t(res_t)) res_ch ();

  rational_arithmetic_unit #(.OPERAND_WIDTH(OperandWidth)) uut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req   (req_ch),
    .res   (res_ch)
  );

  fraction_scoreboard board = new();

  // idle percentages per side, changed by the stimulus as phases go by
  int unsigned send_idle_pct;
  int unsigned recv_stall_pct;
  // request from the stimulus for one long receiver hold-off
  bit long_hold_req;

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // watchdog: a stuck handshake ends the run here
  initial cycles = 0;
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CycleLimit) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // result side: check each accepted result, then pick ready for next edge
  initial begin
    int unsigned hold_left;
    hold_left = 0;
    res_ch.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && res_ch.valid && res_ch.ready) board.check_result(res_ch.data);
      if (long_hold_req && hold_left == 0) begin
        hold_left = LongHold;
        long_hold_req = 1'b0;
      end
      if (hold_left > 0) begin
        // long hold-off so the block sits full and stalls its input
        hold_left--;
        res_ch.ready <= 1'b0;
      end else begin
        res_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // offer one request; valid stays up afterward unless the next call idles
  task automatic send_request(req_t r);
    while ($urandom_range(99) < send_idle_pct) begin
      req_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    req_ch.valid <= 1'b1;
    req_ch.data <= r;
    do @(posedge clk_i); while (!req_ch.ready);
    board.note_request(r);
  endtask

  task automatic send_fields(logic [ModeWidth-1:0] m, logic [31:0] an, logic [30:0] ad,
                             logic [31:0] bn, logic [30:0] bd);
    req_t r;
    r.mode = m;
    r.a_numerator = an;
    r.a_denominator = ad;
    r.b_numerator = bn;
    r.b_denominator = bd;
    send_request(r);
  endtask

  function automatic logic [31:0] pick_numerator();
    case ($urandom_range(3))
      0: return $urandom();
      1: return 32'($signed($urandom_range(2000)) - 1000);
      2: return $urandom_range(1) ? 32'h7fff_ffff - $urandom_range(3)
                                  : 32'h8000_0000 + $urandom_range(3);
      default: return 32'($signed($urandom_range(200_000)) - 100_000);
    endcase
  endfunction

  function automatic logic [30:0] pick_denominator();
    case ($urandom_range(19))
      0: return 31'd0;  // undefined-looking operand still has defined output
      1, 2, 3: return 31'($urandom());
      4: return 31'(32'h7fff_ffff - $urandom_range(3));
      5, 6, 7, 8: return 31'd1;
      default: return 31'($urandom_range(5000, 1));
    endcase
  endfunction

  initial begin
    req_t r;
    rst_ni = 1'b0;
    req_ch.valid <= 1'b0;
    req_ch.data <= '0;
    send_idle_pct = 31;
    recv_stall_pct = 67;
    long_hold_req = 1'b0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: each operation, extremes, and the named corner cases
    send_fields(ModeAdd, 32'd1, 31'd2, 32'd1, 31'd3);
    send_fields(ModeSub, 32'd1, 31'd2, 32'd1, 31'd2);                 // zero result
    send_fields(ModeMul, -32'sd3, 31'd4, 32'd8, 31'd9);
    send_fields(ModeDiv, 32'd5, 31'd7, -32'sd10, 31'd21);              // negative divisor
    send_fields(ModeDiv, 32'd5, 31'd7, 32'd0, 31'd3);                  // divide by zero
    send_fields(ModeMul, 32'h7fff_ffff, 31'd1, 32'h7fff_ffff, 31'd1);  // overflow
    send_fields(ModeMul, 32'h8000_0000, 31'd1, 32'h8000_0000, 31'd1);
    send_fields(ModeSub, 32'h8000_0000, 31'd1, 32'd0, 31'd1);          // most negative fits
    send_fields(ModeSub, 32'd0, 31'd1, 32'h8000_0000, 31'd1);          // 2^31 overflows
    send_fields(ModeAdd, 32'h7fff_ffff, 31'h7fff_ffff, 32'h8000_0000, 31'h7fff_fffe);
    send_fields(ModeMul, 32'd1, 31'h7fff_ffff, 32'd1, 31'd2);          // den overflow
    send_fields(ModeAdd, 32'd3, 31'd0, 32'd4, 31'd5);                  // zero operand den
    send_fields(ModeDiv, 32'd3, 31'd0, 32'd4, 31'd5);
    send_fields(ModeGt, 32'd3, 31'd0, 32'd4, 31'd5);                   // compare with zero den
    send_fields(ModeGt, 32'd1, 31'd2, 32'd2, 31'd4);
    send_fields(ModeGe, 32'd1, 31'd2, 32'd2, 31'd4);
    send_fields(ModeLt, 32'd1, 31'd2, 32'd2, 31'd4);
    send_fields(ModeLe, 32'd1, 31'd2, 32'd2, 31'd4);
    send_fields(ModeLt, -32'sd1, 31'd3, 32'd1, 31'd3);
    send_fields(ModeGt, 32'h8000_0000, 31'h7fff_ffff, 32'h7fff_ffff, 31'd1);
    send_fields(ModeLe, 32'h7fff_ffff, 31'd1, 32'h8000_0000, 31'd1);

    for (int unsigned i = 0; i < RandomRequests; i++) begin
      // three idling phases: receiver-heavy, sender-heavy, then none
      if (i == RandomRequests / 3) begin
        send_idle_pct = 67;
        recv_stall_pct = 31;
      end else if (i == 2 * RandomRequests / 3) begin
        send_idle_pct = 0;
        recv_stall_pct = 0;
        long_hold_req = 1'b1;
      end
      if (i == RandomRequests / 2) begin
        // let the block drain completely before going on
        req_ch.valid <= 1'b0;
        while (board.owed_q.size() != 0) @(posedge clk_i);
      end
      r.mode = ModeWidth'($urandom_range(7));
      r.a_numerator = pick_numerator();
      r.b_numerator = ($urandom_range(15) == 0) ? 32'd0 : pick_numerator();
      r.a_denominator = pick_denominator();
      r.b_denominator = pick_denominator();
      send_request(r);
    end
    req_ch.valid <= 1'b0;

    while (board.owed_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (board.mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end
endmodule
`default_nettype wire
